@@ hdl/lsc_pkg.sv @@
// Shared types and constants for the line segment clipper.
`timescale 1ns / 1ps
`default_nettype none
package lsc_pkg;

    // raster dimension registers and clipped output coordinates
    localparam int DIM_W = 15;
    typedef logic [DIM_W-1:0] t_dim;

    localparam t_dim RESET_WIDTH  = 15'd640;
    localparam t_dim RESET_HEIGHT = 15'd480;

    // intersection quotients saturate at 2**CLAMP_EXP
    localparam int CLAMP_EXP = 40;

    // register indexes on the configuration port
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // per-segment control carried between clip stages
    typedef struct packed {
        logic valid;
        logic ok;
    } t_seg_ctl;

endpackage
`default_nettype wire

@@ hdl/lsc_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per cycle while i_en is high.
`timescale 1ns / 1ps
`default_nettype none
module lsc_div_cell #(
    parameter int WM = 17,
    parameter int WP = 34
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [WM-1:0] i_rem,
    input  wire logic [WP-1:0] i_dvd,
    input  wire logic [WM-1:0] i_div,
    output logic      [WM-1:0] o_rem,
    output logic      [WP-1:0] o_dvd,
    output logic      [WM-1:0] o_div
);

    logic [WM-1:0] r_rem, n_rem;
    logic [WP-1:0] r_dvd, n_dvd;
    logic [WM-1:0] r_div;
    logic [WM:0]   w_trial;
    logic [WM:0]   w_diff;
    logic          w_ge;

    // shift in next dividend bit, subtract divisor if it fits
    always_comb begin
        w_trial = {i_rem, i_dvd[WP-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? w_diff[WM-1:0] : w_trial[WM-1:0];
        n_dvd   = {i_dvd[WP-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
            r_div <= i_div;
        end
    end

    assign o_rem = r_rem;
    assign o_dvd = r_dvd;
    assign o_div = r_div;

endmodule
`default_nettype wire

@@ hdl/lsc_cross.sv @@
// Edge intersection: trunc(b0 + (b1-b0)*(e-a0)/(a1-a0)), pipelined.
`timescale 1ns / 1ps
`default_nettype none
module lsc_cross
    import lsc_pkg::*;
#(
    parameter int WV = 16,
    localparam int WD = WV + 1,
    localparam int WP = 2 * WD,
    localparam int WE = ((WP > CLAMP_EXP) ? WP : CLAMP_EXP + 1) + 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [WV-1:0] i_a0,
    input  wire logic signed [WV-1:0] i_b0,
    input  wire logic signed [WV-1:0] i_a1,
    input  wire logic signed [WV-1:0] i_b1,
    input  wire logic signed [WV-1:0] i_e,
    output logic signed      [WE-1:0] o_val
);

    localparam logic [WE-1:0] Q_CLAMP = {{(WE-1){1'b0}}, 1'b1} << CLAMP_EXP;

    typedef struct packed {
        logic                 neg;
        logic                 zero;
        logic signed [WV-1:0] b0;
    } t_sb;

    logic signed [WD-1:0] w_d, w_n, w_t;
    t_sb                  n_sb;
    t_sb                  r_sb [WP+2];
    logic [WD-1:0]        r0_md, r0_mn, r0_mt;
    logic [WP-1:0]        r1_prod;
    logic [WD-1:0]        r1_div;

    logic [WD-1:0] w_rem [WP+1];
    logic [WP-1:0] w_dvd [WP+1];
    logic [WD-1:0] w_div [WP+1];

    logic [WE-1:0]        w_q;
    logic signed [WE-1:0] w_b0e, w_base, n_val, r_val;
    logic                 w_rnz;
    t_sb                  w_tail;

    // differences, sign of the quotient, magnitudes
    always_comb begin
        w_d = WD'(i_a1) - WD'(i_a0);
        w_n = WD'(i_b1) - WD'(i_b0);
        w_t = WD'(i_e) - WD'(i_a0);
        n_sb.neg  = ((w_n < 0) != (w_t < 0)) != (w_d < 0);
        n_sb.zero = (w_n == 0) || (w_t == 0);
        n_sb.b0   = i_b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_md   <= (w_d < 0) ? WD'(-w_d) : WD'(w_d);
            r0_mn   <= (w_n < 0) ? WD'(-w_n) : WD'(w_n);
            r0_mt   <= (w_t < 0) ? WD'(-w_t) : WD'(w_t);
            r1_prod <= r0_mn * r0_mt;
            r1_div  <= r0_md;
        end
    end

    // sideband travels alongside the divider chain
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= n_sb;
            for (int i = 1; i < WP + 2; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    // divider: one cell per quotient bit
    assign w_rem[0] = '0;
    assign w_dvd[0] = r1_prod;
    assign w_div[0] = r1_div;

    for (genvar k = 0; k < WP; k++) begin : g_cell
        lsc_div_cell #(.WM(WD), .WP(WP)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem[k]),
            .i_dvd (w_dvd[k]),
            .i_div (w_div[k]),
            .o_rem (w_rem[k+1]),
            .o_dvd (w_dvd[k+1]),
            .o_div (w_div[k+1])
        );
    end

    // saturate, apply sign, truncate toward zero
    always_comb begin
        w_tail = r_sb[WP+1];
        w_q    = WE'(w_dvd[WP]);
        if (w_q > Q_CLAMP) begin
            w_q = Q_CLAMP;
        end
        w_rnz = (w_rem[WP] != '0);
        w_b0e = WE'(w_tail.b0);
        if (w_tail.neg) begin
            w_base = w_b0e - signed'(w_q);
            if (w_rnz && (w_base > 0)) begin
                w_base = w_base - 2'sd1;
            end
        end else begin
            w_base = w_b0e + signed'(w_q);
            if (w_rnz && (w_base < 0)) begin
                w_base = w_base + 2'sd1;
            end
        end
        n_val = w_tail.zero ? w_b0e : w_base;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule
`default_nettype wire

@@ hdl/lsc_clip.sv @@
// Clips one endpoint of a segment against the raster edges.
`timescale 1ns / 1ps
`default_nettype none
module lsc_clip
    import lsc_pkg::*;
#(
    parameter int WV = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire t_dim                 i_w,
    input  wire t_dim                 i_h,
    input  wire t_seg_ctl             i_ctl,
    input  wire logic signed [WV-1:0] i_px,
    input  wire logic signed [WV-1:0] i_py,
    input  wire logic signed [WV-1:0] i_qx,
    input  wire logic signed [WV-1:0] i_qy,
    output t_seg_ctl                  o_ctl,
    output logic signed      [WV-1:0] o_px,
    output logic signed      [WV-1:0] o_py,
    output logic signed      [WV-1:0] o_qx,
    output logic signed      [WV-1:0] o_qy
);

    localparam int WD  = WV + 1;
    localparam int WP  = 2 * WD;
    localparam int WE  = ((WP > CLAMP_EXP) ? WP : CLAMP_EXP + 1) + 2;
    localparam int LAT = WP + 3;

    typedef struct packed {
        t_seg_ctl             ctl;
        logic                 in_rect;
        logic                 try_l;
        logic                 try_r;
        logic                 try_t;
        logic                 try_b;
        logic signed [WV-1:0] px;
        logic signed [WV-1:0] py;
        logic signed [WV-1:0] qx;
        logic signed [WV-1:0] qy;
    } t_stage;

    logic signed [WV-1:0] w_wv, w_hv, w_wm1, w_hm1;
    logic signed [WE-1:0] w_we, w_he;
    logic signed [WE-1:0] w_vl, w_vr, w_vt, w_vb;
    t_stage               n_in, w_tl;
    t_stage               r_dl [LAT];
    logic                 w_okl, w_okr, w_okt, w_okb;
    t_seg_ctl             r_ctl, n_ctl;
    logic signed [WV-1:0] r_px, r_py, r_qx, r_qy, n_px, n_py;

    // edge tests on the incoming point
    always_comb begin
        w_wv  = signed'(WV'(i_w));
        w_hv  = signed'(WV'(i_h));
        w_wm1 = w_wv - 2'sd1;
        w_hm1 = w_hv - 2'sd1;
        n_in.ctl     = i_ctl;
        n_in.in_rect = (i_px >= 0) && (i_px < w_wv) && (i_py >= 0) && (i_py < w_hv);
        n_in.try_l   = (i_px < 0) && (i_px != i_qx);
        n_in.try_r   = (i_px >= w_wv) && (i_px != i_qx);
        n_in.try_t   = (i_py < 0) && (i_py != i_qy);
        n_in.try_b   = (i_py >= w_hv) && (i_py != i_qy);
        n_in.px = i_px;
        n_in.py = i_py;
        n_in.qx = i_qx;
        n_in.qy = i_qy;
    end

    // four intersections run side by side
    lsc_cross #(.WV(WV)) u_left (
        .i_clk(i_clk), .i_en(i_en), .i_a0(i_px), .i_b0(i_py),
        .i_a1(i_qx), .i_b1(i_qy), .i_e('0), .o_val(w_vl)
    );
    lsc_cross #(.WV(WV)) u_right (
        .i_clk(i_clk), .i_en(i_en), .i_a0(i_px), .i_b0(i_py),
        .i_a1(i_qx), .i_b1(i_qy), .i_e(w_wm1), .o_val(w_vr)
    );
    lsc_cross #(.WV(WV)) u_top (
        .i_clk(i_clk), .i_en(i_en), .i_a0(i_py), .i_b0(i_px),
        .i_a1(i_qy), .i_b1(i_qx), .i_e('0), .o_val(w_vt)
    );
    lsc_cross #(.WV(WV)) u_bottom (
        .i_clk(i_clk), .i_en(i_en), .i_a0(i_py), .i_b0(i_px),
        .i_a1(i_qy), .i_b1(i_qx), .i_e(w_hm1), .o_val(w_vb)
    );

    // point and flags wait for the intersections
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_dl[i].ctl.valid <= 1'b0;
            end
        end else if (i_en) begin
            r_dl[0] <= n_in;
            for (int i = 1; i < LAT; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    // first edge in order whose intersection lands on the raster wins
    always_comb begin
        w_tl  = r_dl[LAT-1];
        w_we  = signed'(WE'(i_w));
        w_he  = signed'(WE'(i_h));
        w_okl = w_tl.try_l && (w_vl >= 0) && (w_vl < w_he);
        w_okr = w_tl.try_r && (w_vr >= 0) && (w_vr < w_he);
        w_okt = w_tl.try_t && (w_vt >= 0) && (w_vt < w_we);
        w_okb = w_tl.try_b && (w_vb >= 0) && (w_vb < w_we);
        n_px  = w_tl.px;
        n_py  = w_tl.py;
        if (w_tl.in_rect) begin
            n_px = w_tl.px;
        end else if (w_okl) begin
            n_px = '0;
            n_py = w_vl[WV-1:0];
        end else if (w_okr) begin
            n_px = w_wm1;
            n_py = w_vr[WV-1:0];
        end else if (w_okt) begin
            n_px = w_vt[WV-1:0];
            n_py = '0;
        end else if (w_okb) begin
            n_px = w_vb[WV-1:0];
            n_py = w_hm1;
        end
        n_ctl.valid = w_tl.ctl.valid;
        n_ctl.ok    = w_tl.ctl.ok && (w_tl.in_rect || w_okl || w_okr || w_okt || w_okb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_px;
            r_py <= n_py;
            r_qx <= w_tl.qx;
            r_qy <= w_tl.qy;
        end
    end

    assign o_ctl = r_ctl;
    assign o_px  = r_px;
    assign o_py  = r_py;
    assign o_qx  = r_qx;
    assign o_qy  = r_qy;

endmodule
`default_nettype wire

@@ hdl/line_segment_clipper.sv @@
// Top level of the line segment clipper.
`timescale 1ns / 1ps
`default_nettype none
// Clips one segment per cycle, while o_stall is low, to a raster of
// raster_width by raster_height pixels. A new segment is taken every clock
// while o_stall is low. The pipeline is two clip stages in series, each
// built around a chain of restoring-division cells that resolves one
// quotient bit per cell. The output has a register plus one skid entry, so
// input keeps flowing the cycle a result stalls.
// Registers: raster_width at address 0, raster_height at address 4; write
// them only while no segment is in flight.
module line_segment_clipper
    import lsc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_visible,
    output t_dim                              o_clip_start_x,
    output t_dim                              o_clip_start_y,
    output t_dim                              o_clip_end_x,
    output t_dim                              o_clip_end_y
);

    localparam int WV = (COORD_BITS > 16) ? COORD_BITS : 16;

    typedef struct packed {
        logic visible;
        t_dim sx;
        t_dim sy;
        t_dim ex;
        t_dim ey;
    } t_result;

    t_dim                 r_w, r_h;
    t_reg_idx             w_idx;
    logic                 w_en, w_take;
    logic signed [WV-1:0] w_x0, w_y0, w_x1, w_y1, w_wv, w_hv;
    t_seg_ctl             n_ctl, w_c1, w_c2;
    logic signed [WV-1:0] w_p1x, w_p1y, w_q1x, w_q1y;
    logic signed [WV-1:0] w_p2x, w_p2y, w_q2x, w_q2y;
    t_result              w_tail, w_src;
    t_result              r_skid, r_out;
    logic                 r_skid_valid, r_out_valid;

    // configuration port
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= RESET_WIDTH;
            r_h <= RESET_HEIGHT;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_WIDTH:  r_w <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_h <= pwdata[DIM_W-1:0];
                default:    r_w <= r_w;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WIDTH:  prdata = 32'(r_w);
            REG_HEIGHT: prdata = 32'(r_h);
            default:    prdata = '0;
        endcase
    end

    // trivial rejection on the raw endpoints
    always_comb begin
        w_x0 = WV'(i_start_x);
        w_y0 = WV'(i_start_y);
        w_x1 = WV'(i_end_x);
        w_y1 = WV'(i_end_y);
        w_wv = signed'(WV'(r_w));
        w_hv = signed'(WV'(r_h));
        n_ctl.valid = i_valid;
        n_ctl.ok    = (r_w != '0) && (r_h != '0) &&
                      !((w_x0 >= w_wv) && (w_x1 >= w_wv)) &&
                      !((w_x0 < 0) && (w_x1 < 0)) &&
                      !((w_y0 >= w_hv) && (w_y1 >= w_hv)) &&
                      !((w_y0 < 0) && (w_y1 < 0));
    end

    assign w_en = !r_skid_valid;

    // start point first, then end point against the clipped start
    lsc_clip #(.WV(WV)) u_clip_start (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_w(r_w), .i_h(r_h),
        .i_ctl(n_ctl), .i_px(w_x0), .i_py(w_y0), .i_qx(w_x1), .i_qy(w_y1),
        .o_ctl(w_c1), .o_px(w_p1x), .o_py(w_p1y), .o_qx(w_q1x), .o_qy(w_q1y)
    );

    lsc_clip #(.WV(WV)) u_clip_end (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_w(r_w), .i_h(r_h),
        .i_ctl(w_c1), .i_px(w_q1x), .i_py(w_q1y), .i_qx(w_p1x), .i_qy(w_p1y),
        .o_ctl(w_c2), .o_px(w_p2x), .o_py(w_p2y), .o_qx(w_q2x), .o_qy(w_q2y)
    );

    // rejected segments report zero coordinates
    always_comb begin
        w_tail.visible = w_c2.ok;
        w_tail.sx = w_c2.ok ? w_q2x[DIM_W-1:0] : '0;
        w_tail.sy = w_c2.ok ? w_q2y[DIM_W-1:0] : '0;
        w_tail.ex = w_c2.ok ? w_p2x[DIM_W-1:0] : '0;
        w_tail.ey = w_c2.ok ? w_p2y[DIM_W-1:0] : '0;
        w_src  = r_skid_valid ? r_skid : w_tail;
        w_take = !r_out_valid || !i_stall;
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid  <= r_skid_valid || w_c2.valid;
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= w_c2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_src;
        end else if (w_en) begin
            r_skid <= w_tail;
        end
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_visible      = r_out.visible;
    assign o_clip_start_x = r_out.sx;
    assign o_clip_start_y = r_out.sy;
    assign o_clip_end_x   = r_out.ex;
    assign o_clip_end_y   = r_out.ey;

endmodule
`default_nettype wire

@@ hdl/lsc_checker.sv @@
// Port-level checks for the line segment clipper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lsc_checker
    import lsc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_visible,
    input wire t_dim o_clip_start_x,
    input wire t_dim o_clip_start_y,
    input wire t_dim o_clip_end_x,
    input wire t_dim o_clip_end_y
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_visible) &&
        $stable(o_clip_start_x) && $stable(o_clip_end_x) &&
        $stable(o_clip_start_y) && $stable(o_clip_end_y))
        else $error("stalled result changed");

    // rejected segments carry zero coordinates
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> o_clip_start_x == '0 && o_clip_start_y == '0 &&
        o_clip_end_x == '0 && o_clip_end_y == '0)
        else $error("rejected segment with nonzero coordinates");

    // input only backs up behind a stalled result
    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> $past(o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // visible coordinates stay below the largest raster size
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |-> o_clip_start_x != '1 && o_clip_end_x != '1 &&
        o_clip_start_y != '1 && o_clip_end_y != '1)
        else $error("clipped coordinate out of range");

endmodule

bind line_segment_clipper lsc_checker u_lsc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall),
    .o_visible(o_visible), .o_clip_start_x(o_clip_start_x),
    .o_clip_start_y(o_clip_start_y), .o_clip_end_x(o_clip_end_x),
    .o_clip_end_y(o_clip_end_y)
);
`default_nettype wire
